[rtl/msgpack_value_serializer_assert.svh]
// Assertion macros shared by the serializer modules.
// Each use needs clk and arst_n in scope.
`ifndef MSGPACK_VALUE_SERIALIZER_ASSERT_SVH
`define MSGPACK_VALUE_SERIALIZER_ASSERT_SVH

// Check that a condition holds at every clock edge outside reset.
`define MVS_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// Check that the consequent holds in the same cycle as the antecedent.
`define MVS_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define MVS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/msgpk_pkg.sv]
package msgpk_pkg;

	// Command codes
	localparam logic [3:0] CMD_NIL   = 4'd0;
	localparam logic [3:0] CMD_BOOL  = 4'd1;
	localparam logic [3:0] CMD_INT   = 4'd2;
	localparam logic [3:0] CMD_UINT  = 4'd3;
	localparam logic [3:0] CMD_STR   = 4'd4;
	localparam logic [3:0] CMD_BIN   = 4'd5;
	localparam logic [3:0] CMD_ARRAY = 4'd6;
	localparam logic [3:0] CMD_MAP   = 4'd7;
	localparam logic [3:0] CMD_BYTE  = 4'd8;

	// Format tags
	localparam logic [7:0] TAG_NIL      = 8'hc0;
	localparam logic [7:0] TAG_FALSE    = 8'hc2;
	localparam logic [7:0] TAG_TRUE     = 8'hc3;
	localparam logic [7:0] TAG_BIN8     = 8'hc4;
	localparam logic [7:0] TAG_BIN16    = 8'hc5;
	localparam logic [7:0] TAG_BIN32    = 8'hc6;
	localparam logic [7:0] TAG_UINT8    = 8'hcc;
	localparam logic [7:0] TAG_UINT16   = 8'hcd;
	localparam logic [7:0] TAG_UINT32   = 8'hce;
	localparam logic [7:0] TAG_UINT64   = 8'hcf;
	localparam logic [7:0] TAG_INT8     = 8'hd0;
	localparam logic [7:0] TAG_INT16    = 8'hd1;
	localparam logic [7:0] TAG_INT32    = 8'hd2;
	localparam logic [7:0] TAG_INT64    = 8'hd3;
	localparam logic [7:0] TAG_STR8     = 8'hd9;
	localparam logic [7:0] TAG_STR16    = 8'hda;
	localparam logic [7:0] TAG_STR32    = 8'hdb;
	localparam logic [7:0] TAG_ARRAY16  = 8'hdc;
	localparam logic [7:0] TAG_ARRAY32  = 8'hdd;
	localparam logic [7:0] TAG_MAP16    = 8'hde;
	localparam logic [7:0] TAG_MAP32    = 8'hdf;
	localparam logic [7:0] TAG_FIXSTR   = 8'ha0;
	localparam logic [7:0] TAG_FIXARRAY = 8'h90;
	localparam logic [7:0] TAG_FIXMAP   = 8'h80;

	// Default depth of the queue between front and back (at least 2)
	localparam int Q_DEPTH = 4;

	typedef struct packed {
		logic [3:0]  command;
		logic [63:0] value;
	} in_req_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
	} out_req_t;

	// One classified item: tag byte, then nbytes of data, left-aligned
	typedef struct packed {
		logic [7:0]  tag;
		logic [63:0] data;
		logic [3:0]  nbytes;
	} enc_entry_t;

	// Front to queue write side
	typedef struct packed {
		logic       push;
		enc_entry_t entry;
	} q_wr_t;

	// Queue read side to back
	typedef struct packed {
		logic       empty;
		enc_entry_t entry;
	} q_rd_t;

endpackage

[rtl/msgpk_front.sv]
module msgpk_front (
	input  logic               cmd_valid,
	input  logic               q_full,
	input  msgpk_pkg::in_req_t cmd,
	output logic               cmd_stall,
	output msgpk_pkg::q_wr_t   q_wr
);
	import msgpk_pkg::*;

	logic [63:0] v;
	logic [31:0] n;
	logic [7:0]  tag;
	logic [3:0]  nbytes;
	logic        has_out;
	logic [63:0] aligned;

	assign v = cmd.value;
	assign n = v[31:0];

	// Pick the shortest form for the command
	always_comb begin
		tag     = TAG_NIL;
		nbytes  = 4'd0;
		has_out = 1'b1;
		case (cmd.command)
			CMD_NIL: begin
				tag = TAG_NIL;
			end
			CMD_BOOL: begin
				tag = (v != 64'd0) ? TAG_TRUE : TAG_FALSE;
			end
			CMD_INT, CMD_UINT: begin
				if (cmd.command == CMD_INT && v[63]) begin
					if (&v[63:5]) begin
						tag = v[7:0];
					end else if (&v[63:7]) begin
						tag = TAG_INT8;   nbytes = 4'd1;
					end else if (&v[63:15]) begin
						tag = TAG_INT16;  nbytes = 4'd2;
					end else if (&v[63:31]) begin
						tag = TAG_INT32;  nbytes = 4'd4;
					end else begin
						tag = TAG_INT64;  nbytes = 4'd8;
					end
				end else if (v[63:7] == '0) begin
					tag = v[7:0];
				end else if (v[63:8] == '0) begin
					tag = TAG_UINT8;  nbytes = 4'd1;
				end else if (v[63:16] == '0) begin
					tag = TAG_UINT16; nbytes = 4'd2;
				end else if (v[63:32] == '0) begin
					tag = TAG_UINT32; nbytes = 4'd4;
				end else begin
					tag = TAG_UINT64; nbytes = 4'd8;
				end
			end
			CMD_STR: begin
				if (n[31:5] == '0) begin
					tag = TAG_FIXSTR | {3'd0, n[4:0]};
				end else if (n[31:8] == '0) begin
					tag = TAG_STR8;  nbytes = 4'd1;
				end else if (n[31:16] == '0) begin
					tag = TAG_STR16; nbytes = 4'd2;
				end else begin
					tag = TAG_STR32; nbytes = 4'd4;
				end
			end
			CMD_BIN: begin
				if (n[31:8] == '0) begin
					tag = TAG_BIN8;  nbytes = 4'd1;
				end else if (n[31:16] == '0) begin
					tag = TAG_BIN16; nbytes = 4'd2;
				end else begin
					tag = TAG_BIN32; nbytes = 4'd4;
				end
			end
			CMD_ARRAY, CMD_MAP: begin
				if (n[31:4] == '0) begin
					tag = ((cmd.command == CMD_MAP) ? TAG_FIXMAP : TAG_FIXARRAY)
						| {4'd0, n[3:0]};
				end else if (n[31:16] == '0) begin
					tag = (cmd.command == CMD_MAP) ? TAG_MAP16 : TAG_ARRAY16;
					nbytes = 4'd2;
				end else begin
					tag = (cmd.command == CMD_MAP) ? TAG_MAP32 : TAG_ARRAY32;
					nbytes = 4'd4;
				end
			end
			CMD_BYTE: begin
				tag = v[7:0];
			end
			default: begin
				has_out = 1'b0;
			end
		endcase
	end

	// Left-align the data bytes so the back always shifts from the top
	always_comb begin
		case (nbytes)
			4'd1:    aligned = {v[7:0], 56'd0};
			4'd2:    aligned = {v[15:0], 48'd0};
			4'd4:    aligned = {v[31:0], 32'd0};
			4'd8:    aligned = v;
			default: aligned = '0;
		endcase
	end

	assign cmd_stall         = q_full;
	assign q_wr.push         = cmd_valid && !q_full && has_out;
	assign q_wr.entry.tag    = tag;
	assign q_wr.entry.data   = aligned;
	assign q_wr.entry.nbytes = nbytes;

endmodule

[rtl/msgpk_fifo.sv]
module msgpk_fifo #(
	parameter int DEPTH = msgpk_pkg::Q_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  msgpk_pkg::q_wr_t q_wr,
	input  logic             pop,
	output logic             full,
	output msgpk_pkg::q_rd_t q_rd
);
	import msgpk_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	enc_entry_t      mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            empty;

	assign full       = (count_q == CW'(DEPTH));
	assign empty      = (count_q == '0);
	assign q_rd.empty = empty;
	assign q_rd.entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (q_wr.push) begin
			mem_q[wr_ptr_q] <= q_wr.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (q_wr.push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({q_wr.push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

`include "msgpack_value_serializer_assert.svh"

	`MVS_ASSERT_ALWAYS(a_no_push_full, !(q_wr.push && full), "push into full queue")
	`MVS_ASSERT_ALWAYS(a_no_pop_empty, !(pop && empty), "pop from empty queue")
	`MVS_ASSERT_ALWAYS(a_count_range, count_q <= CW'(DEPTH), "queue count overflow")

endmodule

[rtl/msgpk_back.sv]
module msgpk_back (
	input  logic                clk,
	input  logic                arst_n,
	input  msgpk_pkg::q_rd_t    q_rd,
	input  logic                enc_stall,
	output logic                pop,
	output logic                enc_valid,
	output msgpk_pkg::out_req_t enc
);
	import msgpk_pkg::*;

	logic        busy_q;
	logic [63:0] data_q;
	logic [3:0]  cnt_q;
	logic        out_valid_q;
	out_req_t    out_q;
	logic        ld_ok;
	logic        emit;
	out_req_t    out_d;

	assign ld_ok = !out_valid_q || !enc_stall;
	assign pop   = ld_ok && !busy_q && !q_rd.empty;
	assign emit  = ld_ok && (busy_q || !q_rd.empty);

	always_comb begin
		if (busy_q) begin
			out_d.out_byte = data_q[63:56];
			out_d.last     = (cnt_q == 4'd1);
		end else begin
			out_d.out_byte = q_rd.entry.tag;
			out_d.last     = (q_rd.entry.nbytes == 4'd0);
		end
	end

	// Payload of the current item: no reset needed
	always_ff @(posedge clk) begin
		if (ld_ok) begin
			out_q <= out_d;
			if (busy_q) begin
				data_q <= {data_q[55:0], 8'd0};
			end else begin
				data_q <= q_rd.entry.data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (ld_ok) begin
			out_valid_q <= emit;
			if (busy_q) begin
				cnt_q  <= cnt_q - 1'b1;
				busy_q <= (cnt_q != 4'd1);
			end else if (!q_rd.empty) begin
				cnt_q  <= q_rd.entry.nbytes;
				busy_q <= (q_rd.entry.nbytes != 4'd0);
			end
		end
	end

	assign enc_valid = out_valid_q;
	assign enc       = out_q;

`include "msgpack_value_serializer_assert.svh"

	`MVS_ASSERT_SAME(a_pop_idle, pop, !busy_q, "pop while item in progress")
	`MVS_ASSERT_SAME(a_busy_cnt, busy_q, cnt_q != 4'd0, "busy with no bytes left")
	`MVS_ASSERT_NEXT(a_more_bytes, emit && !out_d.last, busy_q,
		"non-final byte sent without item in progress")

endmodule

[rtl/msgpack_value_serializer.sv]
// MessagePack value serializer.
// Command channel (cmd_valid, cmd_stall, cmd): one request per command,
// carrying a 4-bit command code and a 64-bit value. A request is taken at
// a rising edge with cmd_valid high and cmd_stall low.
// Byte channel (enc_valid, enc_stall, enc): one encoded byte per request,
// most significant first, with last set on the final byte of a command.
// Unused command codes are taken and produce no bytes.
// The first byte of a command is written into the queue and then into the
// output register, from which it is shown on enc.
// A command yields its tag byte and then N data bytes, where N is
// the number of data bytes after the tag (0, 1, 2, 4 or 8); one-byte
// encodings stream at one per cycle while enc_stall is low. The byte
// serializer sets the pace; the front accepts until the QUEUE_DEPTH queue fills.
// When the receiver holds enc_stall, the output register keeps its byte,
// the back end halts and cmd_stall rises once the queue is full.
// Reset (arst_n low) empties the queue and drops any byte in flight.
module msgpack_value_serializer #(
	parameter int QUEUE_DEPTH = msgpk_pkg::Q_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_stall,
	input  msgpk_pkg::in_req_t  cmd,
	output logic                enc_valid,
	input  logic                enc_stall,
	output msgpk_pkg::out_req_t enc
);
	import msgpk_pkg::*;

	q_wr_t q_wr;
	q_rd_t q_rd;
	logic  q_full;
	logic  pop;

	// Classify the command and pick the encoding form
	msgpk_front u_front (
		.cmd_valid (cmd_valid),
		.q_full    (q_full),
		.cmd       (cmd),
		.cmd_stall (cmd_stall),
		.q_wr      (q_wr)
	);

	// Hold classified commands so either side can stall on its own
	msgpk_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.q_wr   (q_wr),
		.pop    (pop),
		.full   (q_full),
		.q_rd   (q_rd)
	);

	// Send the tag, then the data bytes, through the output register
	msgpk_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_rd      (q_rd),
		.enc_stall (enc_stall),
		.pop       (pop),
		.enc_valid (enc_valid),
		.enc       (enc)
	);

endmodule
